/* rtl/pmcs_pkg.sv */
// Shared types, constants and the sequencer microprogram for the particle
// motion and collision step. Used by pmcs_ctrl, pmcs_dp and the top level.
// Depends on nothing else.
package pmcs_pkg;

  localparam int ANG_BITS = 30;

  localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
  localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
  localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
  localparam logic signed [63:0] Q30_GAIN    = 64'sd652032874;
  localparam logic signed [63:0] VEC_CLIP    = 64'sd2305843009213693952;
  localparam logic signed [63:0] S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN     = 64'sh8000_0000_0000_0000;

  localparam logic signed [63:0] ATAN_TAB [32] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
    64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
    64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
    64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
    64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047,
    64'sd1023, 64'sd511, 64'sd255, 64'sd127,
    64'sd63, 64'sd31, 64'sd15, 64'sd7,
    64'sd3, 64'sd1, 64'sd0, 64'sd0
  };

  // Request codes.
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_COLLIDE = 2'd1;
  localparam logic [1:0] REQ_FORCE   = 2'd2;
  localparam logic [1:0] REQ_LOAD    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_MASS      = 3'd1;
  localparam logic [2:0] CFG_RADIUS    = 3'd2;
  localparam logic [2:0] CFG_WIDTH     = 3'd3;
  localparam logic [2:0] CFG_HEIGHT    = 3'd4;

  typedef enum logic [3:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_MULF, OP_MUL30, OP_DIV, OP_VEC, OP_ROT,
    OP_BNCX, OP_BNCY
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_PX, S_PY, S_VX, S_VY,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
    S_OX, S_OY, S_SPEED, S_OMASS, S_OANG, S_FORCE, S_LVX, S_LVY,
    S_TS, S_M1, S_GAIN
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_PX, D_PY, D_VX, D_VY,
    D_R0, D_R1, D_R2, D_R3, D_R4, D_R5, D_R6, D_R7
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t sa;
    src_t sb;
    dst_t da;
    dst_t db;
    logic last;
  } uinst_t;

  typedef struct packed {
    logic   capture;
    logic   start;
    uinst_t uinst;
    logic   latch_out;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  // Program entry points.
  localparam logic [5:0] PC_TICK    = 6'd0;
  localparam logic [5:0] PC_LOAD    = 6'd6;
  localparam logic [5:0] PC_FORCE   = 6'd10;
  localparam logic [5:0] PC_COLLIDE = 6'd21;

  function automatic uinst_t mk(op_t op, src_t sa, src_t sb, dst_t da, dst_t db,
                                logic last);
    uinst_t u;
    u.op = op;
    u.sa = sa;
    u.sb = sb;
    u.da = da;
    u.db = db;
    u.last = last;
    return u;
  endfunction

  function automatic uinst_t ucode(logic [5:0] pc);
    uinst_t u;
    case (pc)
      // Tick: move, then bounce off the walls.
      6'd0:  u = mk(OP_MULF,  S_VX,    S_TS,    D_R0, D_NONE, 1'b0);
      6'd1:  u = mk(OP_ADD,   S_PX,    S_R0,    D_PX, D_NONE, 1'b0);
      6'd2:  u = mk(OP_MULF,  S_VY,    S_TS,    D_R0, D_NONE, 1'b0);
      6'd3:  u = mk(OP_ADD,   S_PY,    S_R0,    D_PY, D_NONE, 1'b0);
      6'd4:  u = mk(OP_BNCX,  S_PX,    S_VX,    D_VX, D_NONE, 1'b0);
      6'd5:  u = mk(OP_BNCY,  S_PY,    S_VY,    D_VY, D_NONE, 1'b1);
      // Load.
      6'd6:  u = mk(OP_MOV,   S_OX,    S_ZERO,  D_PX, D_NONE, 1'b0);
      6'd7:  u = mk(OP_MOV,   S_OY,    S_ZERO,  D_PY, D_NONE, 1'b0);
      6'd8:  u = mk(OP_MOV,   S_LVX,   S_ZERO,  D_VX, D_NONE, 1'b0);
      6'd9:  u = mk(OP_MOV,   S_LVY,   S_ZERO,  D_VY, D_NONE, 1'b1);
      // Force toward a point.
      6'd10: u = mk(OP_DIV,   S_FORCE, S_M1,    D_R0, D_NONE, 1'b0);
      6'd11: u = mk(OP_SUB,   S_OX,    S_PX,    D_R1, D_NONE, 1'b0);
      6'd12: u = mk(OP_SUB,   S_OY,    S_PY,    D_R2, D_NONE, 1'b0);
      6'd13: u = mk(OP_VEC,   S_R1,    S_R2,    D_R1, D_NONE, 1'b0);
      6'd14: u = mk(OP_ROT,   S_R1,    S_ZERO,  D_R1, D_R2,   1'b0);
      6'd15: u = mk(OP_MUL30, S_R0,    S_R1,    D_R1, D_NONE, 1'b0);
      6'd16: u = mk(OP_MULF,  S_R1,    S_TS,    D_R1, D_NONE, 1'b0);
      6'd17: u = mk(OP_ADD,   S_VX,    S_R1,    D_VX, D_NONE, 1'b0);
      6'd18: u = mk(OP_MUL30, S_R0,    S_R2,    D_R2, D_NONE, 1'b0);
      6'd19: u = mk(OP_MULF,  S_R2,    S_TS,    D_R2, D_NONE, 1'b0);
      6'd20: u = mk(OP_ADD,   S_VY,    S_R2,    D_VY, D_NONE, 1'b1);
      // Elastic collision.
      6'd21: u = mk(OP_SUB,   S_PX,    S_OX,    D_R0, D_NONE, 1'b0);
      6'd22: u = mk(OP_SUB,   S_PY,    S_OY,    D_R1, D_NONE, 1'b0);
      6'd23: u = mk(OP_VEC,   S_R0,    S_R1,    D_R0, D_NONE, 1'b0);
      6'd24: u = mk(OP_VEC,   S_VX,    S_VY,    D_R2, D_R3,   1'b0);
      6'd25: u = mk(OP_MUL30, S_R3,    S_GAIN,  D_R3, D_NONE, 1'b0);
      6'd26: u = mk(OP_ROT,   S_R0,    S_ZERO,  D_R4, D_R5,   1'b0);
      6'd27: u = mk(OP_SUB,   S_R2,    S_R0,    D_R6, D_NONE, 1'b0);
      6'd28: u = mk(OP_ROT,   S_R6,    S_ZERO,  D_R6, D_R7,   1'b0);
      6'd29: u = mk(OP_SUB,   S_OANG,  S_R0,    D_R2, D_NONE, 1'b0);
      6'd30: u = mk(OP_ROT,   S_R2,    S_ZERO,  D_R2, D_NONE, 1'b0);
      6'd31: u = mk(OP_MUL30, S_R3,    S_R6,    D_R6, D_NONE, 1'b0);
      6'd32: u = mk(OP_SUB,   S_M1,    S_OMASS, D_R1, D_NONE, 1'b0);
      6'd33: u = mk(OP_MULF,  S_R6,    S_R1,    D_R6, D_NONE, 1'b0);
      6'd34: u = mk(OP_ADD,   S_OMASS, S_OMASS, D_R1, D_NONE, 1'b0);
      6'd35: u = mk(OP_MULF,  S_R1,    S_SPEED, D_R1, D_NONE, 1'b0);
      6'd36: u = mk(OP_MUL30, S_R1,    S_R2,    D_R1, D_NONE, 1'b0);
      6'd37: u = mk(OP_ADD,   S_R6,    S_R1,    D_R6, D_NONE, 1'b0);
      6'd38: u = mk(OP_ADD,   S_M1,    S_OMASS, D_R1, D_NONE, 1'b0);
      6'd39: u = mk(OP_DIV,   S_R6,    S_R1,    D_R6, D_NONE, 1'b0);
      6'd40: u = mk(OP_MUL30, S_R3,    S_R7,    D_R7, D_NONE, 1'b0);
      6'd41: u = mk(OP_SUB,   S_ZERO,  S_R5,    D_R0, D_NONE, 1'b0);
      6'd42: u = mk(OP_MUL30, S_R6,    S_R4,    D_R1, D_NONE, 1'b0);
      6'd43: u = mk(OP_MUL30, S_R7,    S_R0,    D_R2, D_NONE, 1'b0);
      6'd44: u = mk(OP_ADD,   S_R1,    S_R2,    D_VX, D_NONE, 1'b0);
      6'd45: u = mk(OP_MUL30, S_R6,    S_R5,    D_R1, D_NONE, 1'b0);
      6'd46: u = mk(OP_MUL30, S_R7,    S_R4,    D_R2, D_NONE, 1'b0);
      6'd47: u = mk(OP_ADD,   S_R1,    S_R2,    D_VY, D_NONE, 1'b1);
      default: u = mk(OP_MOV, S_ZERO,  S_ZERO,  D_NONE, D_NONE, 1'b1);
    endcase
    return u;
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_neg(logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Magnitude and sign back to a signed value, clamped to the 64 bit range.
  function automatic logic signed [63:0] signed_from(logic [63:0] m, logic neg);
    logic [63:0] lim;
    logic [63:0] mc;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mc = (m > lim) ? lim : m;
    return neg ? $signed(-mc) : $signed(mc);
  endfunction

  function automatic logic signed [63:0] clip_vec(logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > VEC_CLIP) begin
      r = VEC_CLIP;
    end else if (v < -VEC_CLIP) begin
      r = -VEC_CLIP;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/pmcs_ctrl.sv */
// Sequencer for the particle step: walks the microprogram held in pmcs_pkg,
// issues one operation at a time to pmcs_dp and owns both handshakes.
module pmcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  output logic                out_valid,
  input  logic                out_ready,
  output pmcs_pkg::dp_cmd_t   cmd,
  input  pmcs_pkg::dp_stat_t  stat
);

  typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_OUT} cstate_t;

  cstate_t         state;
  logic [5:0]      pc;
  pmcs_pkg::uinst_t uinst;
  logic            accept;
  logic            out_free;

  assign in_ready = (state == C_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign uinst    = pmcs_pkg::ucode(pc);

  always_comb begin
    cmd.capture   = accept;
    cmd.start     = (state == C_ISSUE);
    cmd.uinst     = uinst;
    cmd.latch_out = (state == C_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      pc        <= pmcs_pkg::PC_TICK;
      out_valid <= 1'b0;
    end else begin
      if (state == C_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        C_IDLE: begin
          if (accept) begin
            unique case (req_type)
              pmcs_pkg::REQ_TICK:    pc <= pmcs_pkg::PC_TICK;
              pmcs_pkg::REQ_COLLIDE: pc <= pmcs_pkg::PC_COLLIDE;
              pmcs_pkg::REQ_FORCE:   pc <= pmcs_pkg::PC_FORCE;
              pmcs_pkg::REQ_LOAD:    pc <= pmcs_pkg::PC_LOAD;
              default:               pc <= pmcs_pkg::PC_TICK;
            endcase
            state <= C_ISSUE;
          end
        end
        C_ISSUE: begin
          state <= C_WAIT;
        end
        C_WAIT: begin
          if (stat.done) begin
            if (uinst.last) begin
              state <= C_OUT;
            end else begin
              pc    <= pc + 6'd1;
              state <= C_ISSUE;
            end
          end
        end
        C_OUT: begin
          if (out_free) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pmcs_dp.sv */
// Datapath for the particle step: state, scratch registers, configuration,
// and the shared multiplier, divider and CORDIC units. Uses pmcs_pkg.
module pmcs_dp #(
  parameter int WORD_WIDTH        = 32,
  parameter int FRAC_BITS         = 16,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pmcs_pkg::dp_cmd_t         cmd,
  output pmcs_pkg::dp_stat_t        stat,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [30:0]               cfg_data,
  input  logic [30:0]               other_speed,
  input  logic [30:0]               other_mass,
  input  logic signed [18:0]        other_angle,
  input  logic signed [31:0]        other_x,
  input  logic signed [31:0]        other_y,
  input  logic signed [31:0]        force_value,
  input  logic signed [31:0]        load_vx,
  input  logic signed [31:0]        load_vy,
  output logic signed [31:0]        pos_x,
  output logic signed [31:0]        pos_y,
  output logic signed [31:0]        vel_x,
  output logic signed [31:0]        vel_y
);

  localparam int NW    = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

  typedef enum logic [3:0] {
    U_IDLE, U_MUL, U_MULFIN, U_DIV, U_DIVFIN, U_VEC, U_ROTRED, U_ROT, U_WB
  } ustate_t;

  // Configuration.
  logic [16:0] time_step;
  logic [30:0] particle_mass;
  logic [11:0] particle_radius;
  logic [14:0] screen_width;
  logic [14:0] screen_height;

  // Captured request.
  logic [30:0]        in_speed;
  logic [30:0]        in_omass;
  logic signed [18:0] in_oang;
  logic signed [31:0] in_ox;
  logic signed [31:0] in_oy;
  logic signed [31:0] in_force;
  logic signed [31:0] in_lvx;
  logic signed [31:0] in_lvy;

  // Particle state and scratch.
  logic signed [WORD_WIDTH-1:0] px, py, vx, vy;
  logic signed [63:0] px64, py64, vx64, vy64;
  logic signed [63:0] r0, r1, r2, r3, r4, r5, r6, r7;

  // Unit registers.
  ustate_t            ustate;
  pmcs_pkg::dst_t     da, db;
  logic signed [63:0] res_a, res_b;
  logic [63:0]        ma, mb;
  logic               neg;
  logic               s30;
  logic [CNT_W-1:0]   cnt;
  logic [63:0]        pp;
  logic [1:0]         ppk;
  logic [127:0]       acc;
  logic [NW-1:0]      num;
  logic [NW-1:0]      quo;
  logic [63:0]        rem;
  logic signed [63:0] cx, cy, cz;
  logic               flip;

  logic signed [63:0] oang64, rq, wq, hq;
  logic signed [63:0] va, vb;

  assign px64   = 64'(px);
  assign py64   = 64'(py);
  assign vx64   = 64'(vx);
  assign vy64   = 64'(vy);
  assign oang64 = 64'(in_oang) <<< (pmcs_pkg::ANG_BITS - FRAC_BITS);
  assign rq     = $signed(64'(particle_radius) << FRAC_BITS);
  assign wq     = $signed(64'(screen_width) << FRAC_BITS);
  assign hq     = $signed(64'(screen_height) << FRAC_BITS);

  function automatic logic signed [63:0] sat_word(logic signed [63:0] v);
    return (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
  endfunction

  function automatic logic signed [63:0] sel(pmcs_pkg::src_t s);
    logic signed [63:0] v;
    unique case (s)
      pmcs_pkg::S_ZERO:  v = 64'sd0;
      pmcs_pkg::S_PX:    v = px64;
      pmcs_pkg::S_PY:    v = py64;
      pmcs_pkg::S_VX:    v = vx64;
      pmcs_pkg::S_VY:    v = vy64;
      pmcs_pkg::S_R0:    v = r0;
      pmcs_pkg::S_R1:    v = r1;
      pmcs_pkg::S_R2:    v = r2;
      pmcs_pkg::S_R3:    v = r3;
      pmcs_pkg::S_R4:    v = r4;
      pmcs_pkg::S_R5:    v = r5;
      pmcs_pkg::S_R6:    v = r6;
      pmcs_pkg::S_R7:    v = r7;
      pmcs_pkg::S_OX:    v = 64'(in_ox);
      pmcs_pkg::S_OY:    v = 64'(in_oy);
      pmcs_pkg::S_SPEED: v = $signed(64'(in_speed));
      pmcs_pkg::S_OMASS: v = $signed(64'(in_omass));
      pmcs_pkg::S_OANG:  v = oang64;
      pmcs_pkg::S_FORCE: v = 64'(in_force);
      pmcs_pkg::S_LVX:   v = 64'(in_lvx);
      pmcs_pkg::S_LVY:   v = 64'(in_lvy);
      pmcs_pkg::S_TS:    v = $signed(64'(time_step));
      pmcs_pkg::S_M1:    v = $signed(64'(particle_mass));
      pmcs_pkg::S_GAIN:  v = pmcs_pkg::Q30_GAIN;
      default:           v = 64'sd0;
    endcase
    return v;
  endfunction

  assign va = sel(cmd.uinst.sa);
  assign vb = sel(cmd.uinst.sb);

  // Combinational operations.
  logic signed [63:0] alu;
  logic signed [63:0] vxc, vyc;
  always_comb begin
    vxc = pmcs_pkg::clip_vec(va);
    vyc = pmcs_pkg::clip_vec(vb);
    unique case (cmd.uinst.op)
      pmcs_pkg::OP_ADD:  alu = pmcs_pkg::sat_add(va, vb);
      pmcs_pkg::OP_SUB:  alu = pmcs_pkg::sat_add(va, pmcs_pkg::sat_neg(vb));
      pmcs_pkg::OP_BNCX: alu = (va <= rq || va >= wq - rq) ? pmcs_pkg::sat_neg(vb) : vb;
      pmcs_pkg::OP_BNCY: alu = (va <= rq || va >= hq - rq) ? pmcs_pkg::sat_neg(vb) : vb;
      default:           alu = va;
    endcase
  end

  // One CORDIC micro-rotation per cycle, shared by vectoring and rotation.
  logic signed [63:0] dx, dy, at, nx, ny, nz;
  logic               last_iter;
  always_comb begin
    dx = cx >>> cnt;
    dy = cy >>> cnt;
    at = pmcs_pkg::ATAN_TAB[cnt[4:0]];
    if (ustate == U_VEC) begin
      if (cy >= 0) begin
        nx = cx + dy; ny = cy - dx; nz = cz + at;
      end else begin
        nx = cx - dy; ny = cy + dx; nz = cz - at;
      end
    end else begin
      if (cz >= 0) begin
        nx = cx - dy; ny = cy + dx; nz = cz - at;
      end else begin
        nx = cx + dy; ny = cy - dx; nz = cz + at;
      end
    end
  end
  assign last_iter = (cnt == CNT_W'(CORDIC_ITERATIONS - 1));

  // Divider step and product selection.
  logic [64:0]  rem2;
  logic         take;
  logic [63:0]  mul_r;
  logic         mul_ovf;
  logic [127:0] acc_sh;
  assign rem2   = {rem, num[NW-1]};
  assign take   = (rem2 >= {1'b0, mb});
  assign acc_sh = s30 ? (acc >> pmcs_pkg::ANG_BITS) : (acc >> FRAC_BITS);
  assign mul_r  = acc_sh[63:0];
  assign mul_ovf = (acc_sh[127:64] != '0);

  assign stat.done = (ustate == U_WB);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= 17'd65536;
      particle_mass   <= 31'd65536;
      particle_radius <= 12'd10;
      screen_width    <= 15'd1024;
      screen_height   <= 15'd768;
      px     <= '0;
      py     <= '0;
      vx     <= '0;
      vy     <= '0;
      ustate <= U_IDLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pmcs_pkg::CFG_TIME_STEP: time_step       <= cfg_data[16:0];
          pmcs_pkg::CFG_MASS:      particle_mass   <= cfg_data;
          pmcs_pkg::CFG_RADIUS:    particle_radius <= cfg_data[11:0];
          pmcs_pkg::CFG_WIDTH:     screen_width    <= cfg_data[14:0];
          pmcs_pkg::CFG_HEIGHT:    screen_height   <= cfg_data[14:0];
          default: ;
        endcase
      end

      unique case (ustate)
        U_IDLE: begin
          if (cmd.start) begin
            da    <= cmd.uinst.da;
            db    <= cmd.uinst.db;
            res_b <= 64'sd0;
            neg   <= va[63] != vb[63];
            ma    <= pmcs_pkg::mag(va);
            mb    <= pmcs_pkg::mag(vb);
            cnt   <= '0;
            unique case (cmd.uinst.op)
              pmcs_pkg::OP_MULF, pmcs_pkg::OP_MUL30: begin
                s30    <= (cmd.uinst.op == pmcs_pkg::OP_MUL30);
                acc    <= '0;
                ustate <= U_MUL;
              end
              pmcs_pkg::OP_DIV: begin
                if (vb == 64'sd0) begin
                  res_a  <= (va == 64'sd0) ? 64'sd0 :
                            (va[63] ? pmcs_pkg::S64_MIN : pmcs_pkg::S64_MAX);
                  ustate <= U_WB;
                end else begin
                  num    <= {pmcs_pkg::mag(va), {FRAC_BITS{1'b0}}};
                  quo    <= '0;
                  rem    <= '0;
                  ustate <= U_DIV;
                end
              end
              pmcs_pkg::OP_VEC: begin
                if (vxc == 64'sd0 && vyc == 64'sd0) begin
                  res_a  <= 64'sd0;
                  ustate <= U_WB;
                end else begin
                  if (!vxc[63]) begin
                    cx <= vxc; cy <= vyc; cz <= 64'sd0;
                  end else if (!vyc[63]) begin
                    cx <= vyc; cy <= -vxc; cz <= pmcs_pkg::Q30_HALF_PI;
                  end else begin
                    cx <= -vyc; cy <= vxc; cz <= -pmcs_pkg::Q30_HALF_PI;
                  end
                  ustate <= U_VEC;
                end
              end
              pmcs_pkg::OP_ROT: begin
                cz     <= va;
                ustate <= U_ROTRED;
              end
              default: begin
                res_a  <= alu;
                ustate <= U_WB;
              end
            endcase
          end
        end
        U_MUL: begin
          // Four 32x32 partial products, each accumulated in the cycle after it is formed.
          if (cnt <= CNT_W'(3)) begin
            pp  <= (cnt[1] ? ma[63:32] : ma[31:0]) * (cnt[0] ? mb[63:32] : mb[31:0]);
            ppk <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          end
          if (cnt != '0) begin
            acc <= acc + ({64'b0, pp} << {ppk, 5'b0});
          end
          if (cnt == CNT_W'(4)) begin
            ustate <= U_MULFIN;
          end
          cnt <= cnt + CNT_W'(1);
        end
        U_MULFIN: begin
          res_a  <= pmcs_pkg::signed_from(mul_ovf ? '1 : mul_r, neg);
          ustate <= U_WB;
        end
        U_DIV: begin
          rem <= take ? 64'(rem2 - {1'b0, mb}) : rem2[63:0];
          quo <= {quo[NW-2:0], take};
          num <= num << 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NW - 1)) begin
            ustate <= U_DIVFIN;
          end
        end
        U_DIVFIN: begin
          res_a  <= pmcs_pkg::signed_from((quo >> 64) != '0 ? '1 : quo[63:0], neg);
          ustate <= U_WB;
        end
        U_VEC: begin
          cx  <= nx;
          cy  <= ny;
          cz  <= nz;
          cnt <= cnt + CNT_W'(1);
          if (last_iter) begin
            res_a  <= nz;
            res_b  <= nx;
            ustate <= U_WB;
          end
        end
        U_ROTRED: begin
          // Bring the angle into [-pi, pi], then fold into [-pi/2, pi/2].
          if (cz > pmcs_pkg::Q30_PI) begin
            cz <= cz - pmcs_pkg::Q30_TWO_PI;
          end else if (cz < -pmcs_pkg::Q30_PI) begin
            cz <= cz + pmcs_pkg::Q30_TWO_PI;
          end else begin
            if (cz > pmcs_pkg::Q30_HALF_PI) begin
              cz   <= cz - pmcs_pkg::Q30_PI;
              flip <= 1'b1;
            end else if (cz < -pmcs_pkg::Q30_HALF_PI) begin
              cz   <= cz + pmcs_pkg::Q30_PI;
              flip <= 1'b1;
            end else begin
              flip <= 1'b0;
            end
            cx     <= pmcs_pkg::Q30_GAIN;
            cy     <= 64'sd0;
            ustate <= U_ROT;
          end
        end
        U_ROT: begin
          cx  <= nx;
          cy  <= ny;
          cz  <= nz;
          cnt <= cnt + CNT_W'(1);
          if (last_iter) begin
            res_a  <= flip ? -nx : nx;
            res_b  <= flip ? -ny : ny;
            ustate <= U_WB;
          end
        end
        U_WB: begin
          ustate <= U_IDLE;
          unique case (da)
            pmcs_pkg::D_PX: px <= WORD_WIDTH'(sat_word(res_a));
            pmcs_pkg::D_PY: py <= WORD_WIDTH'(sat_word(res_a));
            pmcs_pkg::D_VX: vx <= WORD_WIDTH'(sat_word(res_a));
            pmcs_pkg::D_VY: vy <= WORD_WIDTH'(sat_word(res_a));
            pmcs_pkg::D_R0: r0 <= res_a;
            pmcs_pkg::D_R1: r1 <= res_a;
            pmcs_pkg::D_R2: r2 <= res_a;
            pmcs_pkg::D_R3: r3 <= res_a;
            pmcs_pkg::D_R4: r4 <= res_a;
            pmcs_pkg::D_R5: r5 <= res_a;
            pmcs_pkg::D_R6: r6 <= res_a;
            pmcs_pkg::D_R7: r7 <= res_a;
            default: ;
          endcase
          unique case (db)
            pmcs_pkg::D_R2: r2 <= res_b;
            pmcs_pkg::D_R3: r3 <= res_b;
            pmcs_pkg::D_R5: r5 <= res_b;
            pmcs_pkg::D_R7: r7 <= res_b;
            default: ;
          endcase
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

  // Request capture and the result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_speed <= other_speed;
      in_omass <= other_mass;
      in_oang  <= other_angle;
      in_ox    <= other_x;
      in_oy    <= other_y;
      in_force <= force_value;
      in_lvx   <= load_vx;
      in_lvy   <= load_vy;
    end
    if (cmd.latch_out) begin
      pos_x <= px64[31:0];
      pos_y <= py64[31:0];
      vel_x <= vx64[31:0];
      vel_y <= vy64[31:0];
    end
  end

endmodule

/* rtl/particle_motion_collision_step.sv */
// Top level of the particle motion and collision step.
// Joins the sequencer pmcs_ctrl and the datapath pmcs_dp; uses pmcs_pkg.
//
// Usage. A request arrives on in_valid/in_ready with req_type and its
// operands: tick moves the particle by velocity times time step and bounces
// it off the screen walls, collide replaces the velocity with the elastic
// collision result against a partner, force adds the pull toward a point,
// and load sets position and velocity. Every request answers with exactly
// one result on out_valid/out_ready: the position and velocity afterward.
// Requests are processed one at a time. Tick uses the multiplier, which
// builds each 64 bit product from four 32x32 partial products; force and
// collide also use the shared CORDIC unit and the shared restoring divider.
// The result sits in an output register; while it waits for out_ready the
// block already takes and works on the next request, and holds that one's
// result back until the register is free. Configuration writes on cfg_we
// take effect at once and belong in idle time. A synchronous reset clears
// the particle state to zero and restores the configuration defaults.
module particle_motion_collision_step #(
  parameter int WORD_WIDTH        = 32,
  parameter int FRAC_BITS         = 16,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [30:0]        other_speed,
  input  logic [30:0]        other_mass,
  input  logic signed [18:0] other_angle,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] force_value,
  input  logic signed [31:0] load_vx,
  input  logic signed [31:0] load_vy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  // Commands flow from the sequencer into the datapath; the datapath only
  // reports back when the operation it was given is being written back.
  pmcs_pkg::dp_cmd_t  cmd;
  pmcs_pkg::dp_stat_t stat;

  pmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pmcs_dp #(
    .WORD_WIDTH        (WORD_WIDTH),
    .FRAC_BITS         (FRAC_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .other_speed (other_speed),
    .other_mass  (other_mass),
    .other_angle (other_angle),
    .other_x     (other_x),
    .other_y     (other_y),
    .force_value (force_value),
    .load_vx     (load_vx),
    .load_vy     (load_vy),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .vel_x       (vel_x),
    .vel_y       (vel_y)
  );

endmodule
